// File: sv/positional_insert_shift_queue_defines.svh
// Assertion macros for the positional insert shift queue.
// Used by the top level; expects a clock named i_clk and an active-low reset i_rst_n.
`ifndef POSITIONAL_INSERT_SHIFT_QUEUE_DEFINES_SVH
`define POSITIONAL_INSERT_SHIFT_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/psq_pkg.sv
// Shared types and constants for the positional insert shift queue.
// No dependencies; imported by psq_slots and the top level.
package psq_pkg;

    localparam int VALUE_W  = 32;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 5;
    localparam int M_DATA_W = 40;

    typedef enum logic [MODE_W-1:0] {
        MODE_FRONT  = 2'd0,
        MODE_MIDDLE = 2'd1,
        MODE_TAIL   = 2'd2,
        MODE_REMOVE = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Slot row commands for one cycle; at most one is set.
    typedef struct packed {
        logic insert;
        logic remove;
    } t_slot_ctl;

endpackage

// File: sv/positional_insert_shift_queue.sv
// Positional insert shift queue: input register, slot row and result register.
// Depends on psq_pkg, psq_slots and positional_insert_shift_queue_defines.svh.
//
//  Channel | Direction | tdata (low bit up)             | tuser
//  s_      | in        | value[31:0]                    | mode[1:0]
//  m_      | out       | removed_value[31:0], entry_total[4:0], zeros | status[1:0]
//
// One item is accepted per cycle unless a stalled output backs up; each result passes the
// input register, then the slot row update and result register, before it becomes valid.
// The slot row shifts all entries at once through one multiplexer per slot.
// Reset is synchronous: it empties the queue and drops both valid registers.
// A stalled output holds its result and backs up into the input register.
`include "positional_insert_shift_queue_defines.svh"

module positional_insert_shift_queue
    import psq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [VALUE_W-1:0]  i_s_tdata,   // [31:0] value
    input  logic [MODE_W-1:0]   i_s_tuser,   // [1:0] mode
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,   // [31:0] removed_value, [36:32] entry_total
    output logic [STATUS_W-1:0] o_m_tuser    // [1:0] status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int EXT_W = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;

    logic               r_in_valid;
    t_mode              r_in_mode;
    logic [VALUE_W-1:0] r_in_value;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [VALUE_W-1:0] r_out_removed;
    logic [TOTAL_W-1:0] r_out_total;

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;

    logic               w_advance;
    logic               w_s_fire;
    logic               w_full;
    logic               w_empty;
    logic               w_is_remove;
    t_status            w_status;
    t_slot_ctl          w_ctl;
    logic [IDX_W-1:0]   w_pos;
    logic [VALUE_W-1:0] w_front;
    logic [EXT_W-1:0]   w_count_ext;

    assign w_advance  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;
    assign w_s_fire   = i_s_tvalid && o_s_tready;

    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_is_remove = (r_in_mode == MODE_REMOVE);

    always_comb begin
        w_status = ST_DONE;
        if (w_is_remove && w_empty) begin
            w_status = ST_EMPTY;
        end else if (!w_is_remove && w_full) begin
            w_status = ST_FULL;
        end
    end

    assign w_ctl.remove = w_advance && w_is_remove && !w_empty;
    assign w_ctl.insert = w_advance && !w_is_remove && !w_full;

    // An insert only happens below capacity, so the count fits a slot index.
    always_comb begin
        unique case (r_in_mode)
            MODE_FRONT:  w_pos = '0;
            MODE_MIDDLE: w_pos = IDX_W'(r_count >> 1);
            MODE_TAIL:   w_pos = IDX_W'(r_count);
            MODE_REMOVE: w_pos = '0;
            default:     w_pos = '0;
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_ctl.insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.remove) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign w_count_ext = EXT_W'(n_count);

    psq_slots #(
        .CAPACITY (CAPACITY)
    ) u_slots (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_pos   (w_pos),
        .i_value (r_in_value),
        .o_front (w_front)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (w_s_fire) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_fire) begin
            r_in_mode  <= t_mode'(i_s_tuser);
            r_in_value <= i_s_tdata;
        end
        if (w_advance) begin
            r_out_status  <= w_status;
            r_out_removed <= w_ctl.remove ? w_front : '0;
            r_out_total   <= w_count_ext[TOTAL_W-1:0];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {(M_DATA_W - VALUE_W - TOTAL_W)'(0), r_out_total, r_out_removed};

    `PSQ_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(CAPACITY), "entry count above capacity")
    `PSQ_ASSERT_NEXT(a_insert_grows, w_ctl.insert, r_count == $past(r_count) + CNT_W'(1), "insert did not grow the count")
    `PSQ_ASSERT_NOW(a_reject_zero, r_out_valid && r_out_status != ST_DONE, r_out_removed == '0, "rejected item carries a removed value")
    `PSQ_ASSERT_NOW(a_empty_total, r_out_valid && r_out_status == ST_EMPTY, r_out_total == '0, "empty rejection with nonzero total")

endmodule

// File: sv/psq_slots.sv
// Row of queue slots, each with its own shift/load multiplexer.
// Depends on psq_pkg for the value width and the slot command struct.
module psq_slots
    import psq_pkg::*;
#(
    parameter int CAPACITY = 16,
    localparam int IDX_W = $clog2(CAPACITY)
) (
    input  logic               i_clk,
    input  t_slot_ctl          i_ctl,
    input  logic [IDX_W-1:0]   i_pos,
    input  logic [VALUE_W-1:0] i_value,
    output logic [VALUE_W-1:0] o_front
);

    logic [VALUE_W-1:0] r_slot [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
        logic [VALUE_W-1:0] n_slot;
        logic [VALUE_W-1:0] w_next_up;
        logic [VALUE_W-1:0] w_prev;

        // Missing neighbors at the ends of the row tie to the slot itself; a remove keeps the last slot.
        if (g == CAPACITY - 1) begin : g_last
            assign w_next_up = r_slot[g];
        end else begin : g_mid
            assign w_next_up = r_slot[g+1];
        end
        if (g == 0) begin : g_first
            assign w_prev = r_slot[g];
        end else begin : g_rest
            assign w_prev = r_slot[g-1];
        end

        always_comb begin
            n_slot = r_slot[g];
            if (i_ctl.remove) begin
                n_slot = w_next_up;
            end else if (i_ctl.insert) begin
                if (IDX_W'(g) == i_pos) begin
                    n_slot = i_value;
                end else if (IDX_W'(g) > i_pos) begin
                    n_slot = w_prev;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_slot[g] <= n_slot;
        end
    end

    assign o_front = r_slot[0];

endmodule

// File: tb/tb_positional_insert_shift_queue.sv
// Self-checking testbench for positional_insert_shift_queue: predicts every result of the
// shift queue and checks it field by field. Depends on psq_pkg and the top-level RTL.
module tb_positional_insert_shift_queue
    import psq_pkg::*;
();

    localparam int CAPACITY   = 16;
    localparam int IDLE_LIMIT = 1000;
    localparam int DRAIN_WAIT = 8;

    typedef struct packed {
        t_status            status;
        logic [VALUE_W-1:0] removed;
        logic [TOTAL_W-1:0] total;
    } t_queue_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [VALUE_W-1:0]  i_s_tdata = '0;   // [31:0] value
    logic [MODE_W-1:0]   i_s_tuser = '0;   // [1:0] mode
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [M_DATA_W-1:0] o_m_tdata;        // [31:0] removed_value, [36:32] entry_total
    logic [STATUS_W-1:0] o_m_tuser;        // [1:0] status

    positional_insert_shift_queue #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the slot row and the results still owed by the block.
    logic [VALUE_W-1:0] slot_shadow [CAPACITY];
    int                 slot_count = 0;
    t_queue_result      owed_results[$];
    int                 error_count = 0;

    // Pacing knobs, changed by the initial sequence and the test tasks.
    int rx_stall_pct = 0;
    int rx_hold = 0;
    bit tx_idle = 1'b0;
    int tx_burst_left = 0;
    int idle_cycles = 0;

    function automatic t_queue_result apply_queue_op(t_mode op, logic [VALUE_W-1:0] v);
        t_queue_result r;
        int            pos;
        r.status  = ST_DONE;
        r.removed = '0;
        if (op == MODE_REMOVE) begin
            if (slot_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.removed = slot_shadow[0];
                for (int i = 0; i + 1 < slot_count; i++) slot_shadow[i] = slot_shadow[i + 1];
                slot_count--;
            end
        end else if (slot_count >= CAPACITY) begin
            r.status = ST_FULL;
        end else begin
            case (op)
                MODE_FRONT:  pos = 0;
                MODE_MIDDLE: pos = slot_count / 2;
                default:     pos = slot_count;
            endcase
            for (int i = slot_count; i > pos; i--) slot_shadow[i] = slot_shadow[i - 1];
            slot_shadow[pos] = v;
            slot_count++;
        end
        r.total = slot_count[TOTAL_W-1:0];
        return r;
    endfunction

    // Result check first, then prediction, so a transfer on both sides in one cycle
    // is handled the same way whatever the event order.
    always @(posedge i_clk) begin
        t_queue_result want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (owed_results.size() == 0) begin
                    $display("%0t: unexpected result: status %0d, tdata 0x%h",
                             $time, o_m_tuser, o_m_tdata);
                    error_count++;
                end else begin
                    want = owed_results.pop_front();
                    if (o_m_tuser !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, o_m_tuser);
                        error_count++;
                    end
                    if (o_m_tdata[VALUE_W-1:0] !== want.removed) begin
                        $display("%0t: removed_value mismatch: expected 0x%h, actual 0x%h",
                                 $time, want.removed, o_m_tdata[VALUE_W-1:0]);
                        error_count++;
                    end
                    if (o_m_tdata[VALUE_W+TOTAL_W-1:VALUE_W] !== want.total) begin
                        $display("%0t: entry_total mismatch: expected %0d, actual %0d",
                                 $time, want.total, o_m_tdata[VALUE_W+TOTAL_W-1:VALUE_W]);
                        error_count++;
                    end
                end
            end
            if (i_s_tvalid && o_s_tready)
                owed_results.push_back(apply_queue_op(t_mode'(i_s_tuser), i_s_tdata));
        end
    end

    // Receiver: random stall runs whose density the tests set.
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            i_m_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < rx_stall_pct) begin
            rx_hold = $urandom_range(0, 7);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("positional_insert_shift_queue test failed");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at a falling edge with tvalid still high unless an idle gap dropped it.
    task automatic send_item(t_mode op, logic [VALUE_W-1:0] v);
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= v;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
        gap = 0;
        if (tx_burst_left == 0) begin
            tx_burst_left = $urandom_range(1, 16);
            if (tx_idle) gap = $urandom_range(0, 6);
        end else begin
            tx_burst_left--;
        end
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (owed_results.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_empty_cases();
        send_item(MODE_REMOVE, 32'hFFFF_FFFF);
        send_item(MODE_MIDDLE, 32'h7FFF_FFFF);
        send_item(MODE_REMOVE, 32'h0000_0000);
        send_item(MODE_REMOVE, 32'h1234_5678);
        wait_drained();
    endtask

    task automatic test_positions();
        send_item(MODE_TAIL,   32'h8000_0000);
        send_item(MODE_FRONT,  32'h7FFF_FFFF);
        send_item(MODE_MIDDLE, 32'h0000_0000);
        send_item(MODE_MIDDLE, 32'hFFFF_FFFF);
        send_item(MODE_TAIL,   32'hA5A5_5A5A);
        repeat (5) send_item(MODE_REMOVE, 32'h0);
        wait_drained();
    endtask

    // Fill to capacity, try every insert on the full queue, then remove one and insert in the middle.
    task automatic test_full_rejects();
        for (int i = 0; i < CAPACITY; i++) send_item(MODE_TAIL, pick_value());
        send_item(MODE_FRONT,  32'h1111_1111);
        send_item(MODE_MIDDLE, 32'h2222_2222);
        send_item(MODE_TAIL,   32'h3333_3333);
        send_item(MODE_REMOVE, 32'h0);
        send_item(MODE_MIDDLE, 32'h4444_4444);
        wait_drained();
    endtask

    // Phases lean toward filling or draining so full and empty are both hit often.
    task automatic test_random_mix();
        int insert_pct;
        t_mode op;
        for (int phase = 0; phase < 17; phase++) begin
            if (phase == 8) wait_drained();
            case (phase % 3)
                0:       insert_pct = 85;
                1:       insert_pct = 50;
                default: insert_pct = 15;
            endcase
            if (phase < 2) begin
                rx_stall_pct = 0;
                tx_idle      = 1'b0;
            end else begin
                rx_stall_pct = ($urandom_range(0, 2) == 0) ? 60 : $urandom_range(5, 30);
                tx_idle      = $urandom_range(0, 3) != 0;
            end
            for (int n = 0; n < 40; n++) begin
                if ($urandom_range(0, 99) < insert_pct) op = t_mode'($urandom_range(0, 2));
                else op = MODE_REMOVE;
                send_item(op, pick_value());
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_empty_cases();
        rx_stall_pct = 40;
        tx_idle      = 1'b1;
        test_positions();
        test_full_rejects();
        test_random_mix();
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (error_count == 0 && owed_results.size() == 0) begin
            $display("positional_insert_shift_queue test passed");
        end else begin
            $display("positional_insert_shift_queue test failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/psq_pkg.sv
sv/psq_slots.sv
sv/positional_insert_shift_queue.sv
tb/tb_positional_insert_shift_queue.sv
